@@ rtl/mse_pkg.sv @@
package mse_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int STORE_DEPTH  = 64;
    localparam int AW           = $clog2(STORE_DEPTH);
    localparam int CW           = AW + 1;
    localparam int DATA_W       = 32;
    localparam int CMP_W        = 9;
    localparam int STK_DEPTH    = 8;
    localparam int SPW          = $clog2(STK_DEPTH);
    localparam int Q_DEPTH      = 4;
    localparam int QAW          = $clog2(Q_DEPTH);

    // one loaded item as it travels from the front to the sorter
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              fin;
        logic [AW-1:0]     idx;
    } entry_t;

    // pending range of the top-down recursion
    typedef struct packed {
        logic [AW-1:0] lo;
        logic [AW-1:0] hi;
        logic          right;
    } frame_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SPLIT,
        ST_RETURN,
        ST_COPY,
        ST_PRIME,
        ST_MERGE,
        ST_OUT
    } state_t;

endpackage

@@ rtl/mse_front.sv @@
module mse_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  logic signed [mse_pkg::DATA_W-1:0]   value,
    input  logic                                last,
    input  logic                                q_full,
    output logic                                q_wr_en,
    output mse_pkg::entry_t                     q_wr_data
);

    logic [mse_pkg::AW-1:0] count_reg;
    logic [mse_pkg::AW-1:0] count_next;
    logic                   fin;

    assign fin     = last || (count_reg == mse_pkg::AW'(mse_pkg::MAX_ELEMENTS - 1));
    assign q_wr_en = push && !q_full;

    always_comb
    begin
        q_wr_data.value = value;
        q_wr_data.fin   = fin;
        q_wr_data.idx   = count_reg;
        count_next      = count_reg;
        if (q_wr_en)
        begin
            count_next = fin ? '0 : count_reg + mse_pkg::AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/mse_queue.sv @@
module mse_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  mse_pkg::entry_t wr_data,
    output logic            full,
    input  logic            rd_en,
    output mse_pkg::entry_t rd_data,
    output logic            empty
);

    mse_pkg::entry_t         slot_reg [mse_pkg::Q_DEPTH];
    logic [mse_pkg::QAW-1:0] wptr_reg;
    logic [mse_pkg::QAW-1:0] wptr_next;
    logic [mse_pkg::QAW-1:0] rptr_reg;
    logic [mse_pkg::QAW-1:0] rptr_next;
    logic [mse_pkg::QAW:0]   cnt_reg;
    logic [mse_pkg::QAW:0]   cnt_next;

    assign full    = (cnt_reg == (mse_pkg::QAW+1)'(mse_pkg::Q_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wr_en ? wptr_reg + mse_pkg::QAW'(1) : wptr_reg;
        rptr_next = rd_en ? rptr_reg + mse_pkg::QAW'(1) : rptr_reg;
        cnt_next  = cnt_reg;
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + (mse_pkg::QAW+1)'(1);
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - (mse_pkg::QAW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

@@ rtl/mse_back.sv @@
module mse_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_empty,
    input  mse_pkg::entry_t                     q_rd_data,
    output logic                                q_rd_en,
    input  logic                                pop,
    output logic                                empty,
    output logic signed [mse_pkg::DATA_W-1:0]   sorted_value,
    output logic                                last_res,
    output logic [mse_pkg::CMP_W-1:0]           comparisons
);

    localparam int AW = mse_pkg::AW;
    localparam int CW = mse_pkg::CW;
    localparam int DW = mse_pkg::DATA_W;
    localparam int MW = mse_pkg::CMP_W;
    localparam int SW = mse_pkg::SPW;

    mse_pkg::state_t state_reg, state_next;

    logic [DW-1:0] data_mem    [mse_pkg::STORE_DEPTH];
    logic [DW-1:0] scratch_mem [mse_pkg::STORE_DEPTH];

    mse_pkg::frame_t stk_reg [mse_pkg::STK_DEPTH];
    logic            stk_we;
    logic [SW-1:0]   stk_widx;
    mse_pkg::frame_t stk_wdata;
    logic [SW-1:0]   sp_reg, sp_next;
    logic [SW-1:0]   top_idx;
    mse_pkg::frame_t top;
    logic [AW-1:0]   top_mid;
    logic [AW-1:0]   cur_mid;

    logic [AW-1:0] cur_lo_reg, cur_lo_next;
    logic [AW-1:0] cur_hi_reg, cur_hi_next;
    logic [AW-1:0] m_lo_reg, m_lo_next;
    logic [AW-1:0] m_mid_reg, m_mid_next;
    logic [AW-1:0] m_hi_reg, m_hi_next;
    logic [AW-1:0] wi_reg, wi_next;
    logic [CW-1:0] ci_reg, ci_next;
    logic [CW-1:0] x_reg, x_next;
    logic [CW-1:0] y_reg, y_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] k_reg, k_next;
    logic [MW-1:0] cmp_reg, cmp_next;

    logic          d_we;
    logic [AW-1:0] d_waddr;
    logic [DW-1:0] d_wdata;
    logic          d_rd_en;
    logic [AW-1:0] d_raddr;
    logic [DW-1:0] d_rdata_reg;
    logic          s_we;
    logic [AW-1:0] s_waddr;
    logic [AW-1:0] s_raddr_x;
    logic [AW-1:0] s_raddr_y;
    logic [DW-1:0] s_rx_reg;
    logic [DW-1:0] s_ry_reg;
    logic          x_ok;
    logic          y_ok;
    logic          take_left;

    logic          s1_vld_reg, s1_vld_next;
    logic          s1_last_reg, s1_last_next;
    logic [MW-1:0] s1_cmp_reg, s1_cmp_next;
    logic          out_vld_reg, out_vld_next;
    logic [DW-1:0] out_val_reg, out_val_next;
    logic          out_last_reg, out_last_next;
    logic [MW-1:0] out_cmp_reg, out_cmp_next;
    logic          move;
    logic          issue;

    assign top_idx = sp_reg - SW'(1);
    assign top     = stk_reg[top_idx];
    assign top_mid = AW'(({1'b0, top.lo} + {1'b0, top.hi}) >> 1);
    assign cur_mid = AW'(({1'b0, cur_lo_reg} + {1'b0, cur_hi_reg}) >> 1);

    assign x_ok      = (x_reg <= {1'b0, m_mid_reg});
    assign y_ok      = (y_reg <= {1'b0, m_hi_reg});
    assign take_left = x_ok && (!y_ok || ($signed(s_rx_reg) < $signed(s_ry_reg)));

    assign move  = s1_vld_reg && (!out_vld_reg || pop);
    assign issue = (state_reg == mse_pkg::ST_OUT) && (k_reg != n_reg)
                   && (!s1_vld_reg || move);

    assign empty        = !out_vld_reg;
    assign sorted_value = out_val_reg;
    assign last_res     = out_last_reg;
    assign comparisons  = out_cmp_reg;

    always_comb
    begin
        state_next  = state_reg;
        sp_next     = sp_reg;
        cur_lo_next = cur_lo_reg;
        cur_hi_next = cur_hi_reg;
        m_lo_next   = m_lo_reg;
        m_mid_next  = m_mid_reg;
        m_hi_next   = m_hi_reg;
        wi_next     = wi_reg;
        ci_next     = ci_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        n_next      = n_reg;
        k_next      = k_reg;
        cmp_next    = cmp_reg;
        q_rd_en     = 1'b0;
        stk_we      = 1'b0;
        stk_widx    = sp_reg;
        stk_wdata   = top;
        d_we        = 1'b0;
        d_waddr     = wi_reg;
        d_wdata     = s_rx_reg;
        d_rd_en     = 1'b0;
        d_raddr     = ci_reg[AW-1:0];
        s_we        = 1'b0;
        s_waddr     = AW'(ci_reg - CW'(1));
        s_raddr_x   = x_reg[AW-1:0];
        s_raddr_y   = y_reg[AW-1:0];

        case (state_reg)
            mse_pkg::ST_LOAD:
            begin
                if (!q_empty)
                begin
                    q_rd_en = 1'b1;
                    d_we    = 1'b1;
                    d_waddr = q_rd_data.idx;
                    d_wdata = q_rd_data.value;
                    if (q_rd_data.fin)
                    begin
                        n_next      = {1'b0, q_rd_data.idx} + CW'(1);
                        cmp_next    = '0;
                        cur_lo_next = '0;
                        cur_hi_next = q_rd_data.idx;
                        sp_next     = '0;
                        state_next  = mse_pkg::ST_SPLIT;
                    end
                end
            end
            mse_pkg::ST_SPLIT:
            begin
                if (cur_lo_reg >= cur_hi_reg)
                begin
                    state_next = mse_pkg::ST_RETURN;
                end
                else
                begin
                    stk_we          = 1'b1;
                    stk_widx        = sp_reg;
                    stk_wdata.lo    = cur_lo_reg;
                    stk_wdata.hi    = cur_hi_reg;
                    stk_wdata.right = 1'b0;
                    sp_next         = sp_reg + SW'(1);
                    cur_hi_next     = cur_mid;
                end
            end
            mse_pkg::ST_RETURN:
            begin
                if (sp_reg == '0)
                begin
                    k_next     = '0;
                    state_next = mse_pkg::ST_OUT;
                end
                else if (!top.right)
                begin
                    stk_we          = 1'b1;
                    stk_widx        = top_idx;
                    stk_wdata.right = 1'b1;
                    cur_lo_next     = top_mid + AW'(1);
                    cur_hi_next     = top.hi;
                    state_next      = mse_pkg::ST_SPLIT;
                end
                else
                begin
                    m_lo_next  = top.lo;
                    m_hi_next  = top.hi;
                    m_mid_next = top_mid;
                    ci_next    = {1'b0, top.lo};
                    state_next = mse_pkg::ST_COPY;
                end
            end
            mse_pkg::ST_COPY:
            begin
                // read runs one step ahead of the scratch write
                if (ci_reg <= {1'b0, m_hi_reg})
                begin
                    d_rd_en = 1'b1;
                end
                if (ci_reg != {1'b0, m_lo_reg})
                begin
                    s_we = 1'b1;
                end
                if (ci_reg == {1'b0, m_hi_reg} + CW'(1))
                begin
                    state_next = mse_pkg::ST_PRIME;
                end
                else
                begin
                    ci_next = ci_reg + CW'(1);
                end
            end
            mse_pkg::ST_PRIME:
            begin
                s_raddr_x  = m_lo_reg;
                s_raddr_y  = m_mid_reg + AW'(1);
                x_next     = {1'b0, m_lo_reg};
                y_next     = {1'b0, m_mid_reg} + CW'(1);
                wi_next    = m_lo_reg;
                state_next = mse_pkg::ST_MERGE;
            end
            mse_pkg::ST_MERGE:
            begin
                d_we     = 1'b1;
                d_waddr  = wi_reg;
                d_wdata  = take_left ? s_rx_reg : s_ry_reg;
                cmp_next = cmp_reg + MW'(1);
                if (take_left)
                begin
                    x_next = x_reg + CW'(1);
                end
                else
                begin
                    y_next = y_reg + CW'(1);
                end
                s_raddr_x = x_next[AW-1:0];
                s_raddr_y = y_next[AW-1:0];
                if (wi_reg == m_hi_reg)
                begin
                    sp_next    = sp_reg - SW'(1);
                    state_next = mse_pkg::ST_RETURN;
                end
                else
                begin
                    wi_next = wi_reg + AW'(1);
                end
            end
            mse_pkg::ST_OUT:
            begin
                d_raddr = k_reg[AW-1:0];
                if (issue)
                begin
                    d_rd_en = 1'b1;
                    k_next  = k_reg + CW'(1);
                end
                if ((k_reg == n_reg) && !s1_vld_reg)
                begin
                    state_next = mse_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = mse_pkg::ST_LOAD;
            end
        endcase
    end

    // read stage and output register of the result side
    always_comb
    begin
        s1_vld_next   = s1_vld_reg;
        s1_last_next  = s1_last_reg;
        s1_cmp_next   = s1_cmp_reg;
        out_vld_next  = out_vld_reg;
        out_val_next  = out_val_reg;
        out_last_next = out_last_reg;
        out_cmp_next  = out_cmp_reg;
        if (move)
        begin
            out_vld_next  = 1'b1;
            out_val_next  = d_rdata_reg;
            out_last_next = s1_last_reg;
            out_cmp_next  = s1_cmp_reg;
            s1_vld_next   = 1'b0;
        end
        else if (pop)
        begin
            out_vld_next = 1'b0;
        end
        if (issue)
        begin
            s1_vld_next  = 1'b1;
            s1_last_next = (k_reg + CW'(1) == n_reg);
            s1_cmp_next  = (k_reg + CW'(1) == n_reg) ? cmp_reg : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_we)
        begin
            data_mem[d_waddr] <= d_wdata;
        end
        if (d_rd_en)
        begin
            d_rdata_reg <= data_mem[d_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            scratch_mem[s_waddr] <= d_rdata_reg;
        end
        s_rx_reg <= scratch_mem[s_raddr_x];
        s_ry_reg <= scratch_mem[s_raddr_y];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_reg[stk_widx] <= stk_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mse_pkg::ST_LOAD;
            sp_reg      <= '0;
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sp_reg      <= sp_next;
            s1_vld_reg  <= s1_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_lo_reg   <= cur_lo_next;
        cur_hi_reg   <= cur_hi_next;
        m_lo_reg     <= m_lo_next;
        m_mid_reg    <= m_mid_next;
        m_hi_reg     <= m_hi_next;
        wi_reg       <= wi_next;
        ci_reg       <= ci_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        n_reg        <= n_next;
        k_reg        <= k_next;
        cmp_reg      <= cmp_next;
        s1_last_reg  <= s1_last_next;
        s1_cmp_reg   <= s1_cmp_next;
        out_val_reg  <= out_val_next;
        out_last_reg <= out_last_next;
        out_cmp_reg  <= out_cmp_next;
    end

endmodule

@@ rtl/merge_sort_engine.sv @@
// Sorts sets of up to 64 signed 32-bit values in ascending order (top-down merge sort,
// right-hand value first on a tie). Push one value per item; an item with last set, or
// the 64th item, closes the set. The sorted values then come out one per pop, the final
// one with last_res set and the set's comparison count (total length of all merged
// ranges, 0 for a single value). Items go through a four-entry queue, so a few items of
// the next set are taken while a set is sorted. The sort runs on one shared merge unit
// over a data memory with one write and one read port and a scratch memory with two
// read ports: a merge copies its range to scratch, takes a read-ahead step, then writes
// one value per cycle; each range of the recursion also takes a split and a return step.
// Results stream out at one per cycle while pop is held, behind a registered read stage.
module merge_sort_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [mse_pkg::DATA_W-1:0]   value,
    input  logic                                last,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [mse_pkg::DATA_W-1:0]   sorted_value,
    output logic                                last_res,
    output logic [mse_pkg::CMP_W-1:0]           comparisons
);

    logic            q_wr_en;
    mse_pkg::entry_t q_wr_data;
    logic            q_rd_en;
    mse_pkg::entry_t q_rd_data;
    logic            q_empty;

    mse_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .value     (value),
        .last      (last),
        .q_full    (full),
        .q_wr_en   (q_wr_en),
        .q_wr_data (q_wr_data)
    );

    mse_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr_en),
        .wr_data (q_wr_data),
        .full    (full),
        .rd_en   (q_rd_en),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    mse_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_rd_data    (q_rd_data),
        .q_rd_en      (q_rd_en),
        .pop          (pop),
        .empty        (empty),
        .sorted_value (sorted_value),
        .last_res     (last_res),
        .comparisons  (comparisons)
    );

endmodule

@@ rtl/mse_checker.sv @@
module mse_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                push,
    input logic                                full,
    input logic signed [mse_pkg::DATA_W-1:0]   value,
    input logic                                last,
    input logic                                empty,
    input logic                                pop,
    input logic signed [mse_pkg::DATA_W-1:0]   sorted_value,
    input logic                                last_res,
    input logic [mse_pkg::CMP_W-1:0]           comparisons
);

    // count only shows on the closing item of a set
    a_cmp_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !last_res) |-> (comparisons == '0))
        else $error("comparison count on a non-final item");

    a_cmp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last_res) |-> (comparisons <= mse_pkg::CMP_W'(384)))
        else $error("comparison count out of range");

    // within a set, values come out in ascending order
    a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last_res) ##1 !empty
        |-> (sorted_value >= $past(sorted_value, 1)))
        else $error("sorted items out of order");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(sorted_value) && $stable(last_res)
                              && $stable(comparisons)))
        else $error("waiting result changed");

endmodule

bind merge_sort_engine mse_checker u_mse_checker (.*);

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam logic signed [mse_pkg::DATA_W-1:0] VMIN = 32'h8000_0000;
    localparam logic signed [mse_pkg::DATA_W-1:0] VMAX = 32'h7FFF_FFFF;
    localparam int HOLD_CYCLES = 1500;
    localparam int ITEM_TARGET = 400;

    typedef struct {
        logic signed [mse_pkg::DATA_W-1:0] value;
        logic                              fin;
        logic [mse_pkg::CMP_W-1:0]         count;
    } sorted_item_t;

    class sort_scoreboard;
        sorted_item_t expected_q[$];
        int           open_set[$];
        int           arr[mse_pkg::MAX_ELEMENTS];
        int           tmp[mse_pkg::MAX_ELEMENTS];
        int           merge_steps;
        int           errors;

        // top-down split at floor((lo+hi)/2); on a tie the right side goes first
        function void sort_range(int lo, int hi);
            int mid;
            int x;
            int y;
            if (lo >= hi)
                return;
            mid = (lo + hi) / 2;
            sort_range(lo, mid);
            sort_range(mid + 1, hi);
            for (int i = lo; i <= hi; i++)
                tmp[i] = arr[i];
            x = lo;
            y = mid + 1;
            for (int i = lo; i <= hi; i++)
            begin
                merge_steps++;
                if (x <= mid && (y > hi || tmp[x] < tmp[y]))
                begin
                    arr[i] = tmp[x];
                    x++;
                end
                else
                begin
                    arr[i] = tmp[y];
                    y++;
                end
            end
        endfunction

        function void note_input(logic signed [mse_pkg::DATA_W-1:0] v, logic l);
            sorted_item_t r;
            int           n;
            open_set.push_back(v);
            if (!l && open_set.size() < mse_pkg::MAX_ELEMENTS)
                return;
            n = open_set.size();
            foreach (open_set[k])
                arr[k] = open_set[k];
            merge_steps = 0;
            sort_range(0, n - 1);
            for (int k = 0; k < n; k++)
            begin
                r.value = arr[k];
                r.fin   = (k == n - 1);
                r.count = (k == n - 1) ? mse_pkg::CMP_W'(merge_steps) : '0;
                expected_q.push_back(r);
            end
            open_set.delete();
        endfunction

        function void check_result(logic signed [mse_pkg::DATA_W-1:0] v, logic l,
                                   logic [mse_pkg::CMP_W-1:0] c);
            sorted_item_t e;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result item: sorted_value %0d", v);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (v !== e.value)
            begin
                $error("sorted_value mismatch: expected %0d, actual %0d", e.value, v);
                errors++;
            end
            if (l !== e.fin)
            begin
                $error("last_res mismatch: expected %0d, actual %0d", e.fin, l);
                errors++;
            end
            if (c !== e.count)
            begin
                $error("comparisons mismatch: expected %0d, actual %0d", e.count, c);
                errors++;
            end
        endfunction
    endclass

    logic                              clk   = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              push  = 1'b0;
    logic signed [mse_pkg::DATA_W-1:0] value = '0;
    logic                              last  = 1'b0;
    logic                              pop   = 1'b0;
    logic                              full;
    logic                              empty;
    logic signed [mse_pkg::DATA_W-1:0] sorted_value;
    logic                              last_res;
    logic [mse_pkg::CMP_W-1:0]         comparisons;

    sort_scoreboard                    sb = new();
    int                                send_idle_pct = 0;
    int                                recv_idle_pct = 0;
    bit                                hold_req = 1'b0;
    int                                items_sent = 0;
    logic signed [mse_pkg::DATA_W-1:0] set_buf[$];

    merge_sort_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .value        (value),
        .last         (last),
        .empty        (empty),
        .pop          (pop),
        .sorted_value (sorted_value),
        .last_res     (last_res),
        .comparisons  (comparisons)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                sb.note_input(value, last);
            if (pop && !empty)
                sb.check_result(sorted_value, last_res, comparisons);
        end
    end

    initial
    begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // receiver; a hold request stalls it for a long stretch
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_item(input logic signed [mse_pkg::DATA_W-1:0] v, input logic l);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push  <= 1'b1;
        value <= v;
        last  <= l;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_set(input logic mark_last);
        foreach (set_buf[k])
            send_item(set_buf[k], mark_last && (k == set_buf.size() - 1));
        set_buf.delete();
    endtask

    function automatic logic signed [mse_pkg::DATA_W-1:0] pick_value(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(6) - 3;
            default:
                case ($urandom_range(4))
                    0: return VMIN;
                    1: return VMAX;
                    2: return 0;
                    3: return -1;
                    default: return $urandom;
                endcase
        endcase
    endfunction

    // drop push and wait for the clock first so the monitor has noted the last accepted item
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int  phase;
        int  n;
        int  mode;
        int  r;
        bit  need_full;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 27;
        recv_idle_pct = 62;

        // single values at both extremes, then a pair of them
        set_buf = '{VMIN};
        send_set(1'b1);
        set_buf = '{VMAX};
        send_set(1'b1);
        set_buf = '{VMAX, VMIN};
        send_set(1'b1);
        // extremes mixed with repeated max values, then repeated and descending values
        set_buf = '{0, -1, 1, VMAX, VMIN, VMAX};
        send_set(1'b1);
        set_buf = '{7, 7, 7};
        send_set(1'b1);
        set_buf = '{5, 4, 3, 2, 1, 0, -1};
        send_set(1'b1);

        phase = 1;
        need_full = 1'b1;
        while (items_sent < ITEM_TARGET)
        begin
            if (phase == 1 && items_sent >= ITEM_TARGET / 3)
            begin
                phase = 2;
                send_idle_pct = 62;
                recv_idle_pct = 27;
                hold_req = 1'b1;
            end
            else if (phase == 2 && items_sent >= 2 * ITEM_TARGET / 3)
            begin
                phase = 3;
                drain();
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            r = $urandom_range(99);
            if (need_full || r < 8)
                n = mse_pkg::MAX_ELEMENTS;
            else if (r < 20)
                n = $urandom_range(mse_pkg::MAX_ELEMENTS - 1, 13);
            else
                n = $urandom_range(12, 1);
            mode = $urandom_range(2);
            for (int k = 0; k < n; k++)
                set_buf.push_back(pick_value(mode));
            // a full store closes the set whatever last says
            send_set(n < mse_pkg::MAX_ELEMENTS ? 1'b1
                                               : ((need_full ? 1'b0 : 1'($urandom))));
            need_full = 1'b0;
        end

        drain();
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0 && sb.open_set.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
